// ----- src/gsfc_pkg.sv -----
// ----------------------------------------------------------------------------
// gsfc_pkg
// Shared types, constants and functions of the sensor frame checker.
// ----------------------------------------------------------------------------
package gsfc_pkg;

  // Frame layout
  localparam int FRAME_BYTES_DEF = 12;
  localparam int POS_W           = 4;

  localparam logic [POS_W-1:0] POS_GAS_HI  = 4'd0;
  localparam logic [POS_W-1:0] POS_GAS_LO  = 4'd1;
  localparam logic [POS_W-1:0] POS_GAS_CRC = 4'd2;
  localparam logic [POS_W-1:0] POS_TMP_HI  = 4'd3;
  localparam logic [POS_W-1:0] POS_TMP_LO  = 4'd4;
  localparam logic [POS_W-1:0] POS_TMP_CRC = 4'd5;
  localparam logic [POS_W-1:0] POS_HUM_HI  = 4'd6;
  localparam logic [POS_W-1:0] POS_HUM_LO  = 4'd7;
  localparam logic [POS_W-1:0] POS_HUM_CRC = 4'd8;

  // CRC-8, MSB first, no final xor
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Scaling: value = floor(span * raw / 65535) - offset
  localparam int SCALED_W = 15;
  localparam int PROD_W   = 31;
  localparam logic [SCALED_W-1:0] TEMP_SPAN = 15'd17500;
  localparam logic [SCALED_W-1:0] TEMP_OFS  = 15'd4500;
  localparam logic [SCALED_W-1:0] HUM_SPAN  = 15'd12500;
  localparam logic [SCALED_W-1:0] HUM_OFS   = 15'd600;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // One checked frame as handed from front to back
  typedef struct packed {
    logic        ok;
    logic [15:0] gas;
    logic [15:0] temp_raw;
    logic [15:0] humid_raw;
  } frame_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Eight shift steps of the CRC register after the byte has been xored in
  function automatic logic [7:0] crc8_byte(input logic [7:0] c_in);
    logic [7:0] c;
    c = c_in;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // floor(x / 65535) for x < 2^31: x = q0*65536 + lo gives remainder lo + q0,
  // which stays below twice the divisor, so one correction suffices
  function automatic logic [SCALED_W-1:0] div65535(input logic [PROD_W-1:0] x);
    logic [SCALED_W-1:0] q0;
    logic [16:0]         rem;
    q0  = x[PROD_W-1:16];
    rem = {1'b0, x[15:0]} + 17'(q0);
    return (rem >= 17'd65535) ? (q0 + 15'd1) : q0;
  endfunction

endpackage

// ----- src/gsfc_front.sv -----
// ----------------------------------------------------------------------------
// gsfc_front
// Takes frame bytes, assembles the three words, checks their CRCs and hands
// one frame record to the queue on the last byte.
// ----------------------------------------------------------------------------
module gsfc_front #(
  parameter int FRAME_BYTES = gsfc_pkg::FRAME_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             data_byte,
  input  logic                   frame_start,
  input  logic                   push,
  input  gsfc_pkg::q_stat_t      q_stat,
  output logic                   q_push,
  output gsfc_pkg::frame_t       q_frame
);

  localparam logic [gsfc_pkg::POS_W-1:0] LAST_POS = gsfc_pkg::POS_W'(FRAME_BYTES - 1);

  logic [gsfc_pkg::POS_W-1:0] pos_r, pos_nxt, pos_cur;
  logic                       good_r, good_nxt, good_cur, good_upd;
  logic [7:0]                 hold_r, hold_nxt;
  logic [7:0]                 crc_r, crc_nxt;
  logic [15:0]                gas_r, gas_nxt, tmp_r, tmp_nxt, hum_r, hum_nxt;
  logic                       acc, last;

  // item accepted only while the queue has room, whatever its position
  assign acc  = push && !q_stat.full;
  assign pos_cur  = frame_start ? '0 : pos_r;
  assign good_cur = frame_start ? 1'b1 : good_r;
  assign last = (pos_cur >= LAST_POS);

  // per-position handling of the byte
  always_comb begin
    hold_nxt = hold_r;
    crc_nxt  = crc_r;
    gas_nxt  = gas_r;
    tmp_nxt  = tmp_r;
    hum_nxt  = hum_r;
    good_upd = good_cur;
    case (pos_cur)
      gsfc_pkg::POS_GAS_HI, gsfc_pkg::POS_TMP_HI, gsfc_pkg::POS_HUM_HI: begin
        hold_nxt = data_byte;
        crc_nxt  = gsfc_pkg::crc8_byte(gsfc_pkg::CRC_INIT ^ data_byte);
      end
      gsfc_pkg::POS_GAS_LO: begin
        gas_nxt = {hold_r, data_byte};
        crc_nxt = gsfc_pkg::crc8_byte(crc_r ^ data_byte);
      end
      gsfc_pkg::POS_TMP_LO: begin
        tmp_nxt = {hold_r, data_byte};
        crc_nxt = gsfc_pkg::crc8_byte(crc_r ^ data_byte);
      end
      gsfc_pkg::POS_HUM_LO: begin
        hum_nxt = {hold_r, data_byte};
        crc_nxt = gsfc_pkg::crc8_byte(crc_r ^ data_byte);
      end
      gsfc_pkg::POS_GAS_CRC, gsfc_pkg::POS_TMP_CRC, gsfc_pkg::POS_HUM_CRC: begin
        good_upd = good_cur && (crc_r == data_byte);
      end
      default: begin
      end
    endcase
  end

  // position and verdict restart after the last byte
  assign pos_nxt  = last ? '0 : (pos_cur + 1'b1);
  assign good_nxt = last ? 1'b1 : good_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      good_r <= 1'b1;
    end else if (acc) begin
      pos_r  <= pos_nxt;
      good_r <= good_nxt;
    end
  end

  // word registers
  always_ff @(posedge clk) begin
    if (acc) begin
      hold_r <= hold_nxt;
      crc_r  <= crc_nxt;
      gas_r  <= gas_nxt;
      tmp_r  <= tmp_nxt;
      hum_r  <= hum_nxt;
    end
  end

  // frame record to the queue
  assign q_push            = acc && last;
  assign q_frame.ok        = good_upd;
  assign q_frame.gas       = gas_nxt;
  assign q_frame.temp_raw  = tmp_nxt;
  assign q_frame.humid_raw = hum_nxt;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS)
    else $error("frame position beyond last byte");

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && last) |=> (pos_r == '0) && good_r)
    else $error("position or verdict not restarted after last byte");

endmodule

// ----- src/gsfc_queue.sv -----
// ----------------------------------------------------------------------------
// gsfc_queue
// Short queue of frame records between the front and the back.
// ----------------------------------------------------------------------------
module gsfc_queue #(
  parameter int DEPTH = gsfc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gsfc_pkg::frame_t  wr_frame,
  input  logic              pop,
  output gsfc_pkg::frame_t  rd_frame,
  output gsfc_pkg::q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  gsfc_pkg::frame_t  slot_r [DEPTH];
  logic [PTR_W-1:0]  wptr_r, rptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : (wptr_r + 1'b1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : (rptr_r + 1'b1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= wr_frame;
    end
  end

  assign rd_frame = slot_r[rptr_r];

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count lost a push");

endmodule

// ----- src/gsfc_back.sv -----
// ----------------------------------------------------------------------------
// gsfc_back
// Scales the raw temperature and humidity words to hundredths over two
// stages: multiply, then divide by 65535 and remove the offset.
// ----------------------------------------------------------------------------
module gsfc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gsfc_pkg::q_stat_t            q_stat,
  input  gsfc_pkg::frame_t             q_frame,
  output logic                         q_pop,
  output logic                         res_valid,
  input  logic                         res_pop,
  output logic                         check_ok,
  output logic [15:0]                  gas_ppm,
  output logic signed [gsfc_pkg::SCALED_W-1:0] temp_centi,
  output logic signed [gsfc_pkg::SCALED_W-1:0] humid_centi
);

  // stage 1: products
  logic                         s1_valid_r;
  logic                         s1_ok_r;
  logic [15:0]                  s1_gas_r;
  logic [gsfc_pkg::PROD_W-1:0]  s1_tprod_r, s1_hprod_r;
  // stage 2: result register
  logic                         s2_valid_r;
  logic                         s2_ok_r;
  logic [15:0]                  s2_gas_r;
  logic [gsfc_pkg::SCALED_W-1:0] s2_temp_r, s2_hum_r;
  logic                         s1_ready, s2_ready;

  assign s2_ready = !s2_valid_r || res_pop;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign q_pop    = !q_stat.empty && s1_ready;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= !q_stat.empty;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // multiply by span
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_ok_r    <= q_frame.ok;
      s1_gas_r   <= q_frame.gas;
      s1_tprod_r <= gsfc_pkg::PROD_W'(q_frame.temp_raw) *
                    gsfc_pkg::PROD_W'(gsfc_pkg::TEMP_SPAN);
      s1_hprod_r <= gsfc_pkg::PROD_W'(q_frame.humid_raw) *
                    gsfc_pkg::PROD_W'(gsfc_pkg::HUM_SPAN);
    end
  end

  // divide by full scale and take off the offset (two's complement wrap)
  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_ok_r   <= s1_ok_r;
      s2_gas_r  <= s1_gas_r;
      s2_temp_r <= gsfc_pkg::div65535(s1_tprod_r) - gsfc_pkg::TEMP_OFS;
      s2_hum_r  <= gsfc_pkg::div65535(s1_hprod_r) - gsfc_pkg::HUM_OFS;
    end
  end

  assign res_valid   = s2_valid_r;
  assign check_ok    = s2_ok_r;
  assign gas_ppm     = s2_gas_r;
  assign temp_centi  = $signed(s2_temp_r);
  assign humid_centi = $signed(s2_hum_r);

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |=> s1_valid_r && $stable(s1_tprod_r))
    else $error("stage 1 product lost while result stalled");

endmodule

// ----- src/gas_sensor_frame_checker.sv -----
// ----------------------------------------------------------------------------
// gas_sensor_frame_checker
// Sensor frame checker: CRC-8 per word, CO2 word and scaled temperature and
// humidity, one result per frame.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, frames back to back; input stalls only
//   while the frame queue is full because results are not being taken.
// Result path: the last byte of a frame is written to the queue as it is taken,
//   then the record passes the multiply and divide registers to the out_ ports.
// Reset: synchronous rst_n clears position, verdict, queue and stage flags;
//   the block takes bytes in the first cycle after reset.
// ----------------------------------------------------------------------------
module gas_sensor_frame_checker #(
  parameter int FRAME_BYTES = gsfc_pkg::FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH = gsfc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [7:0]                            in_data_byte,
  input  logic                                  in_frame_start,
  input  logic                                  push,
  output logic                                  full,
  output logic                                  out_check_ok,
  output logic [15:0]                           out_gas_ppm,
  output logic signed [gsfc_pkg::SCALED_W-1:0]  out_temp_centi,
  output logic signed [gsfc_pkg::SCALED_W-1:0]  out_humid_centi,
  output logic                                  empty,
  input  logic                                  pop
);

  gsfc_pkg::q_stat_t q_stat;
  gsfc_pkg::frame_t  wr_frame, rd_frame;
  logic              q_push, q_pop, res_valid;

  // front: byte intake and CRC check
  gsfc_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .data_byte   (in_data_byte),
    .frame_start (in_frame_start),
    .push        (push),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_frame     (wr_frame)
  );

  // frame record queue
  gsfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_frame (wr_frame),
    .pop      (q_pop),
    .rd_frame (rd_frame),
    .stat     (q_stat)
  );

  // back: scaling pipeline and result register
  gsfc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .q_frame     (rd_frame),
    .q_pop       (q_pop),
    .res_valid   (res_valid),
    .res_pop     (pop),
    .check_ok    (out_check_ok),
    .gas_ppm     (out_gas_ppm),
    .temp_centi  (out_temp_centi),
    .humid_centi (out_humid_centi)
  );

  assign full  = q_stat.full;
  assign empty = !res_valid;

endmodule
